>>> hdl/cac_pkg.sv
// cac_pkg: shared codes and constants of the consensus acceptor.
// Used by cac_front, cac_back and consensus_acceptor; depends on nothing.
package cac_pkg;

    // operation codes of an input transaction
    localparam logic [2:0] FUNC_PREPARE   = 3'd0;
    localparam logic [2:0] FUNC_ACCEPT    = 3'd1;
    localparam logic [2:0] FUNC_PERSISTED = 3'd2;
    localparam logic [2:0] FUNC_RECOVER   = 3'd3;
    localparam logic [2:0] FUNC_TICK      = 3'd4;

    // message kinds of a result transaction
    localparam logic [2:0] MSG_NONE      = 3'd0;
    localparam logic [2:0] MSG_PROMISE   = 3'd1;
    localparam logic [2:0] MSG_PREP_NACK = 3'd2;
    localparam logic [2:0] MSG_PERMIT    = 3'd3;
    localparam logic [2:0] MSG_ACC_NACK  = 3'd4;

    // configuration register file
    localparam int CFG_DATA_BITS = 32;
    localparam int TICK_BITS     = 32;
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ACTIVE   = 1'b0;
    localparam cfg_idx_t CFG_LIVENESS = 1'b1;

    localparam logic [TICK_BITS-1:0] LIVENESS_RESET = 32'd1000;

endpackage

>>> hdl/cac_intf.sv
// cac_intf: valid/ready channel interfaces for requests and result messages.
// Depends on nothing; widths follow the block parameters.
interface cac_req_if #(
    parameter int ID_BITS    = 48,
    parameter int VALUE_BITS = 64,
    parameter int UID_BITS   = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            func;
    logic [UID_BITS-1:0]   from_uid;
    logic [ID_BITS-1:0]    proposal_id;
    logic [ID_BITS-1:0]    accepted_in;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, func, from_uid, proposal_id, accepted_in, value,
                    input ready);
    modport sink (input valid, func, from_uid, proposal_id, accepted_in, value,
                  output ready);
endinterface

interface cac_rsp_if #(
    parameter int ID_BITS    = 48,
    parameter int VALUE_BITS = 64,
    parameter int UID_BITS   = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            msg_kind;
    logic [UID_BITS-1:0]   dest_uid;
    logic [ID_BITS-1:0]    msg_proposal_id;
    logic [ID_BITS-1:0]    msg_other_id;
    logic [VALUE_BITS-1:0] msg_value;
    logic                  persist_needed;
    logic                  prepare_expired;
    logic                  last;

    modport source (output valid, msg_kind, dest_uid, msg_proposal_id, msg_other_id,
                    msg_value, persist_needed, prepare_expired, last,
                    input ready);
    modport sink (input valid, msg_kind, dest_uid, msg_proposal_id, msg_other_id,
                  msg_value, persist_needed, prepare_expired, last,
                  output ready);
endinterface

>>> hdl/cac_front.sv
// cac_front: accepts request transactions, updates acceptor state and builds jobs.
// Depends on cac_pkg and cac_req_if; holds the configuration registers.
module cac_front #(
    parameter int ID_BITS    = 48,
    parameter int VALUE_BITS = 64,
    parameter int UID_BITS   = 16,
    parameter int JOB_BITS   = 3 + 2*UID_BITS + 3*ID_BITS + 2*VALUE_BITS + 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cac_req_if.sink                            req,
    input  logic                               cfg_we,
    input  cac_pkg::cfg_idx_t                  cfg_index,
    input  logic [cac_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               q_full,
    output logic                               push,
    output logic [JOB_BITS-1:0]                job
);
    import cac_pkg::*;

    typedef struct packed {
        logic [2:0]            kind;
        logic [UID_BITS-1:0]   dest;
        logic [ID_BITS-1:0]    pid;
        logic [ID_BITS-1:0]    other;
        logic [VALUE_BITS-1:0] val;
        logic                  two;
        logic [UID_BITS-1:0]   dest1;
        logic [ID_BITS-1:0]    pid1;
        logic [VALUE_BITS-1:0] val1;
        logic                  persist;
        logic                  expired;
    } job_t;

    logic                  active_reg;
    logic [TICK_BITS-1:0]  window_reg;

    logic [ID_BITS-1:0]    promised_reg,   promised_next;
    logic [ID_BITS-1:0]    acc_id_reg,     acc_id_next;
    logic [VALUE_BITS-1:0] acc_val_reg,    acc_val_next;
    logic                  prom_pend_reg,  prom_pend_next;
    logic [UID_BITS-1:0]   prom_uid_reg,   prom_uid_next;
    logic                  acc_pend_reg,   acc_pend_next;
    logic [UID_BITS-1:0]   acc_uid_reg,    acc_uid_next;
    logic [TICK_BITS-1:0]  idle_reg,       idle_next;

    job_t job_d;

    // take a transaction whenever the queue has room
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;
    assign job       = job_d;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            window_reg <= LIVENESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE:   active_reg <= cfg_data[0];
                CFG_LIVENESS: window_reg <= cfg_data[TICK_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // decode the operation and compute next state and messages
    always_comb
    begin
        promised_next  = promised_reg;
        acc_id_next    = acc_id_reg;
        acc_val_next   = acc_val_reg;
        prom_pend_next = prom_pend_reg;
        prom_uid_next  = prom_uid_reg;
        acc_pend_next  = acc_pend_reg;
        acc_uid_next   = acc_uid_reg;
        idle_next      = idle_reg;

        job_d       = '0;
        job_d.kind  = MSG_NONE;
        job_d.dest1 = acc_uid_reg;
        job_d.pid1  = acc_id_reg;
        job_d.val1  = acc_val_reg;

        unique case (req.func)
            FUNC_PREPARE:
            begin
                if (promised_reg != '0 && req.proposal_id == promised_reg)
                begin
                    if (active_reg)
                    begin
                        job_d.kind  = MSG_PROMISE;
                        job_d.dest  = req.from_uid;
                        job_d.pid   = req.proposal_id;
                        job_d.other = acc_id_reg;
                        job_d.val   = acc_val_reg;
                    end
                end
                else if (promised_reg == '0 || req.proposal_id > promised_reg)
                begin
                    if (!prom_pend_reg)
                    begin
                        promised_next = req.proposal_id;
                        if (active_reg)
                        begin
                            prom_pend_next = 1'b1;
                            prom_uid_next  = req.from_uid;
                        end
                    end
                end
                else if (active_reg)
                begin
                    job_d.kind  = MSG_PREP_NACK;
                    job_d.dest  = req.from_uid;
                    job_d.pid   = req.proposal_id;
                    job_d.other = promised_reg;
                end
                idle_next = '0;
            end
            FUNC_ACCEPT:
            begin
                if (acc_id_reg != '0 && req.proposal_id == acc_id_reg
                    && req.value == acc_val_reg)
                begin
                    if (active_reg)
                    begin
                        job_d.kind = MSG_PERMIT;
                        job_d.dest = req.from_uid;
                        job_d.pid  = req.proposal_id;
                        job_d.val  = req.value;
                    end
                end
                else if (promised_reg == '0 || req.proposal_id >= promised_reg)
                begin
                    if (!acc_pend_reg)
                    begin
                        promised_next = req.proposal_id;
                        acc_id_next   = req.proposal_id;
                        acc_val_next  = req.value;
                        if (active_reg)
                        begin
                            acc_pend_next = 1'b1;
                            acc_uid_next  = req.from_uid;
                        end
                    end
                end
                else if (active_reg)
                begin
                    job_d.kind  = MSG_ACC_NACK;
                    job_d.dest  = req.from_uid;
                    job_d.pid   = req.proposal_id;
                    job_d.other = promised_reg;
                end
            end
            FUNC_PERSISTED:
            begin
                if (active_reg)
                begin
                    if (prom_pend_reg)
                    begin
                        job_d.kind  = MSG_PROMISE;
                        job_d.dest  = prom_uid_reg;
                        job_d.pid   = promised_reg;
                        job_d.other = acc_id_reg;
                        job_d.val   = acc_val_reg;
                        job_d.two   = acc_pend_reg;
                    end
                    else if (acc_pend_reg)
                    begin
                        job_d.kind = MSG_PERMIT;
                        job_d.dest = acc_uid_reg;
                        job_d.pid  = acc_id_reg;
                        job_d.val  = acc_val_reg;
                    end
                end
                prom_pend_next = 1'b0;
                prom_uid_next  = '0;
                acc_pend_next  = 1'b0;
                acc_uid_next   = '0;
            end
            FUNC_RECOVER:
            begin
                promised_next = req.proposal_id;
                acc_id_next   = req.accepted_in;
                acc_val_next  = req.value;
            end
            FUNC_TICK:
            begin
                if (idle_reg != '1)
                    idle_next = idle_reg + TICK_BITS'(1);
            end
            default: ;
        endcase

        job_d.persist = prom_pend_next || acc_pend_next;
        job_d.expired = idle_next > window_reg;
    end

    // commit state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            promised_reg  <= '0;
            acc_id_reg    <= '0;
            acc_val_reg   <= '0;
            prom_pend_reg <= 1'b0;
            prom_uid_reg  <= '0;
            acc_pend_reg  <= 1'b0;
            acc_uid_reg   <= '0;
            idle_reg      <= '0;
        end
        else if (push)
        begin
            promised_reg  <= promised_next;
            acc_id_reg    <= acc_id_next;
            acc_val_reg   <= acc_val_next;
            prom_pend_reg <= prom_pend_next;
            prom_uid_reg  <= prom_uid_next;
            acc_pend_reg  <= acc_pend_next;
            acc_uid_reg   <= acc_uid_next;
            idle_reg      <= idle_next;
        end
    end

endmodule

>>> hdl/cac_queue.sv
// cac_queue: short register-based FIFO of jobs between front and back.
// Depends on nothing; width and depth are parameters.
module cac_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    entries_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg,  count_next;

    assign full  = count_reg == CNT_BITS'(DEPTH);
    assign empty = count_reg == '0;
    assign rdata = entries_reg[rd_ptr_reg];

    // advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        if (push && !pop)
            count_next = count_reg + CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the incoming job
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= wdata;
    end

endmodule

>>> hdl/cac_back.sv
// cac_back: drains jobs from the queue and presents result transactions.
// Depends on cac_pkg and cac_rsp_if; splits two-message jobs into two results.
module cac_back #(
    parameter int ID_BITS    = 48,
    parameter int VALUE_BITS = 64,
    parameter int UID_BITS   = 16,
    parameter int JOB_BITS   = 3 + 2*UID_BITS + 3*ID_BITS + 2*VALUE_BITS + 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [JOB_BITS-1:0] job,
    input  logic                q_empty,
    output logic                pop,
    cac_rsp_if.source           rsp
);
    import cac_pkg::*;

    typedef struct packed {
        logic [2:0]            kind;
        logic [UID_BITS-1:0]   dest;
        logic [ID_BITS-1:0]    pid;
        logic [ID_BITS-1:0]    other;
        logic [VALUE_BITS-1:0] val;
        logic                  two;
        logic [UID_BITS-1:0]   dest1;
        logic [ID_BITS-1:0]    pid1;
        logic [VALUE_BITS-1:0] val1;
        logic                  persist;
        logic                  expired;
    } job_t;

    job_t head;

    logic                  out_valid_reg, out_valid_next;
    logic                  second_reg,    second_next;
    logic                  slot_free;
    logic                  load_second;

    logic [2:0]            kind_reg;
    logic [UID_BITS-1:0]   dest_reg;
    logic [ID_BITS-1:0]    pid_reg;
    logic [ID_BITS-1:0]    other_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  persist_reg;
    logic                  expired_reg;
    logic                  last_reg;
    logic [UID_BITS-1:0]   sec_dest_reg;
    logic [ID_BITS-1:0]    sec_pid_reg;
    logic [VALUE_BITS-1:0] sec_val_reg;

    assign head        = job_t'(job);
    assign slot_free   = !out_valid_reg || rsp.ready;
    assign load_second = slot_free && second_reg;
    assign pop         = slot_free && !second_reg && !q_empty;

    assign rsp.valid           = out_valid_reg;
    assign rsp.msg_kind        = kind_reg;
    assign rsp.dest_uid        = dest_reg;
    assign rsp.msg_proposal_id = pid_reg;
    assign rsp.msg_other_id    = other_reg;
    assign rsp.msg_value       = val_reg;
    assign rsp.persist_needed  = persist_reg;
    assign rsp.prepare_expired = expired_reg;
    assign rsp.last            = last_reg;

    // output slot control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        second_next    = second_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            second_next    = head.two;
        end
        else if (load_second)
        begin
            out_valid_next = 1'b1;
            second_next    = 1'b0;
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // load the first message of a job, or the held permit of a two-message job
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg     <= head.kind;
            dest_reg     <= head.dest;
            pid_reg      <= head.pid;
            other_reg    <= head.other;
            val_reg      <= head.val;
            persist_reg  <= head.persist;
            expired_reg  <= head.expired;
            last_reg     <= !head.two;
            sec_dest_reg <= head.dest1;
            sec_pid_reg  <= head.pid1;
            sec_val_reg  <= head.val1;
        end
        else if (load_second)
        begin
            kind_reg  <= MSG_PERMIT;
            dest_reg  <= sec_dest_reg;
            pid_reg   <= sec_pid_reg;
            other_reg <= '0;
            val_reg   <= sec_val_reg;
            last_reg  <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    // a held second message always sits behind a shown first one
    a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (out_valid_reg && !last_reg))
        else $error("second message pending without a first message shown");

    // a non-final result is followed by the permit of the same job
    a_permit_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp.ready && !last_reg) |=>
            (out_valid_reg && kind_reg == MSG_PERMIT && last_reg))
        else $error("non-final result not followed by a permit");

    // a status-only result is always the final one
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == MSG_NONE) |-> last_reg)
        else $error("status-only result not marked last");
`endif

endmodule

>>> hdl/consensus_acceptor.sv
// consensus_acceptor: top level of the single-instance consensus acceptor.
// Depends on cac_pkg, cac_intf, cac_front, cac_queue and cac_back.
//
// Usage:
//   req  - request transactions (prepare, accept, persisted, recover, tick).
//   rsp  - result transactions; each request yields one result, or two for a
//          persisted request that releases both a promise and a permit; the
//          final result of a request has last set.
//   cfg  - write port: cfg_we, cfg_index (0 active, 1 liveness window), cfg_data.
// With an empty queue, an accepted request's job is written into the queue and
// then loaded into the output register, from which its result is shown.
// Throughput: one request per cycle while the queue has room; a two-result
// request holds the output register until both of its results are taken.
// A queue of QUEUE_DEPTH jobs separates front and back, so req.ready drops only
// once the queue is full: under a stalled receiver, or after enough two-result
// requests have built up a backlog.
// Reset clears all acceptor state to invalid/zero, sets active to 1 and the
// liveness window to 1000, and empties the queue and the output register.
// A stalled receiver holds the shown result stable until it is taken.
module consensus_acceptor #(
    parameter int ID_BITS     = 48,
    parameter int VALUE_BITS  = 64,
    parameter int UID_BITS    = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cac_req_if.sink                            req,
    cac_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  cac_pkg::cfg_idx_t                  cfg_index,
    input  logic [cac_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import cac_pkg::*;

    localparam int JOB_BITS = 3 + 2*UID_BITS + 3*ID_BITS + 2*VALUE_BITS + 3;

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [JOB_BITS-1:0] q_wdata;
    logic [JOB_BITS-1:0] q_rdata;

    // classify requests and update state
    cac_front #(
        .ID_BITS    (ID_BITS),
        .VALUE_BITS (VALUE_BITS),
        .UID_BITS   (UID_BITS),
        .JOB_BITS   (JOB_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (q_push),
        .job       (q_wdata)
    );

    // decouple front from back
    cac_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // emit result transactions
    cac_back #(
        .ID_BITS    (ID_BITS),
        .VALUE_BITS (VALUE_BITS),
        .UID_BITS   (UID_BITS),
        .JOB_BITS   (JOB_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (q_rdata),
        .q_empty (q_empty),
        .pop     (q_pop),
        .rsp     (rsp)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for consensus_acceptor (prepare/accept/persist flow).
// Depends on cac_pkg, cac_intf and consensus_acceptor from the hdl folder.
module testbench;
    import cac_pkg::*;

    localparam int ID_W       = 48;
    localparam int VAL_W      = 64;
    localparam int UID_W      = 16;
    localparam int CLK_PERIOD = 10;
    localparam int RAND_ITEMS_PER_PHASE = 100;
    localparam int RAND_PHASES          = 6;
    localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        logic [2:0]       func;
        logic [UID_W-1:0] uid;
        logic [ID_W-1:0]  pid;
        logic [ID_W-1:0]  acc;
        logic [VAL_W-1:0] val;
    } request_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [UID_W-1:0] dest;
        logic [ID_W-1:0]  pid;
        logic [ID_W-1:0]  other;
        logic [VAL_W-1:0] val;
        logic             persist;
        logic             expired;
        logic             last;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    cac_req_if #(.ID_BITS(ID_W), .VALUE_BITS(VAL_W), .UID_BITS(UID_W)) req_ch ();
    cac_rsp_if #(.ID_BITS(ID_W), .VALUE_BITS(VAL_W), .UID_BITS(UID_W)) rsp_ch ();

    consensus_acceptor #(
        .ID_BITS    (ID_W),
        .VALUE_BITS (VAL_W),
        .UID_BITS   (UID_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // acceptor state as the bench expects it
    logic             cfg_active;
    logic [31:0]      cfg_window;
    logic [ID_W-1:0]  promised;
    logic [ID_W-1:0]  acc_id;
    logic [VAL_W-1:0] acc_val;
    logic             promise_armed;
    logic [UID_W-1:0] promise_dest;
    logic             permit_armed;
    logic [UID_W-1:0] permit_dest;
    logic [31:0]      idle_ticks;

    request_t request_queue[$];
    reply_t   pending_replies[$];
    int       queued_total = 0;
    int       taken_total  = 0;
    int       fail_count   = 0;

    bit send_jitter = 1'b1;
    bit recv_jitter = 1'b1;
    bit req_fire    = 1'b0;
    bit rsp_fire    = 1'b0;
    int send_gap    = 0;
    int recv_stall  = 0;

    // stimulus generator state
    logic [ID_W-1:0]  id_base  = 48'd16;
    logic [ID_W-1:0]  last_pid = 48'd16;
    logic [VAL_W-1:0] last_val = '0;

    function automatic reply_t make_msg(logic [2:0] kind, logic [UID_W-1:0] dest,
                                        logic [ID_W-1:0] pid, logic [ID_W-1:0] other,
                                        logic [VAL_W-1:0] val);
        reply_t m;
        m = '0;
        m.kind  = kind;
        m.dest  = dest;
        m.pid   = pid;
        m.other = other;
        m.val   = val;
        return m;
    endfunction

    // Update the expected state for one request and queue the messages it yields
    task automatic predict_replies(input request_t r);
        reply_t msgs[$];
        reply_t m;
        case (r.func)
            FUNC_PREPARE:
            begin
                if (promised != 0 && r.pid == promised)
                begin
                    if (cfg_active)
                        msgs.push_back(make_msg(MSG_PROMISE, r.uid, r.pid, acc_id, acc_val));
                end
                else if (promised == 0 || r.pid > promised)
                begin
                    // a busy slot drops the request; only the idle count is still cleared
                    if (!promise_armed)
                    begin
                        promised = r.pid;
                        if (cfg_active)
                        begin
                            promise_armed = 1'b1;
                            promise_dest  = r.uid;
                        end
                    end
                end
                else if (cfg_active)
                    msgs.push_back(make_msg(MSG_PREP_NACK, r.uid, r.pid, promised, '0));
                idle_ticks = '0;
            end
            FUNC_ACCEPT:
            begin
                if (acc_id != 0 && r.pid == acc_id && r.val == acc_val)
                begin
                    if (cfg_active)
                        msgs.push_back(make_msg(MSG_PERMIT, r.uid, r.pid, '0, r.val));
                end
                else if (promised == 0 || r.pid >= promised)
                begin
                    if (!permit_armed)
                    begin
                        promised = r.pid;
                        acc_id   = r.pid;
                        acc_val  = r.val;
                        if (cfg_active)
                        begin
                            permit_armed = 1'b1;
                            permit_dest  = r.uid;
                        end
                    end
                end
                else if (cfg_active)
                    msgs.push_back(make_msg(MSG_ACC_NACK, r.uid, r.pid, promised, '0));
            end
            FUNC_PERSISTED:
            begin
                // release the promise first, then the permit
                if (cfg_active)
                begin
                    if (promise_armed)
                        msgs.push_back(make_msg(MSG_PROMISE, promise_dest, promised,
                                                acc_id, acc_val));
                    if (permit_armed)
                        msgs.push_back(make_msg(MSG_PERMIT, permit_dest, acc_id, '0, acc_val));
                end
                promise_armed = 1'b0;
                promise_dest  = '0;
                permit_armed  = 1'b0;
                permit_dest   = '0;
            end
            FUNC_RECOVER:
            begin
                promised = r.pid;
                acc_id   = r.acc;
                acc_val  = r.val;
            end
            FUNC_TICK:
            begin
                if (idle_ticks != '1)
                    idle_ticks = idle_ticks + 1;
            end
            default: ;
        endcase
        if (msgs.size() == 0)
            msgs.push_back(make_msg(MSG_NONE, '0, '0, '0, '0));
        // status reflects the state after the whole request
        foreach (msgs[k])
        begin
            m         = msgs[k];
            m.persist = promise_armed || permit_armed;
            m.expired = idle_ticks > cfg_window;
            m.last    = (k == msgs.size() - 1);
            pending_replies.push_back(m);
        end
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic check_reply(input reply_t got);
        reply_t want;
        if (pending_replies.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result at %0t: kind %0d dest %h pid %h", $realtime,
                         got.kind, got.dest, got.pid);
        end
        else
        begin
            want = pending_replies.pop_front();
            if (got.kind !== want.kind || got.dest !== want.dest || got.pid !== want.pid ||
                got.other !== want.other || got.val !== want.val ||
                got.persist !== want.persist || got.expired !== want.expired ||
                got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"mismatch at %0t (expected/actual): kind %0d/%0d dest %h/%h ",
                              "pid %h/%h other %h/%h value %h/%h persist %0b/%0b ",
                              "expired %0b/%0b last %0b/%0b"}, $realtime,
                             want.kind, got.kind, want.dest, got.dest, want.pid, got.pid,
                             want.other, got.other, want.val, got.val,
                             want.persist, got.persist, want.expired, got.expired,
                             want.last, got.last);
            end
        end
    endtask

    // Sample both handshakes; predict on request transactions, check result transactions
    always @(posedge clk)
    begin : monitor
        reply_t got;
        if (rst_n)
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            rsp_fire <= rsp_ch.valid && rsp_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                taken_total++;
                predict_replies('{func: req_ch.func, uid: req_ch.from_uid,
                                  pid: req_ch.proposal_id, acc: req_ch.accepted_in,
                                  val: req_ch.value});
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.kind    = rsp_ch.msg_kind;
                got.dest    = rsp_ch.dest_uid;
                got.pid     = rsp_ch.msg_proposal_id;
                got.other   = rsp_ch.msg_other_id;
                got.val     = rsp_ch.msg_value;
                got.persist = rsp_ch.persist_needed;
                got.expired = rsp_ch.prepare_expired;
                got.last    = rsp_ch.last;
                check_reply(got);
            end
        end
    end

    // Present queued requests, holding each until taken, with a random gap after it
    always @(negedge clk)
    begin : driver
        request_t nxt;
        if (rst_n && (!req_ch.valid || req_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                nxt = request_queue.pop_front();
                req_ch.func        <= nxt.func;
                req_ch.from_uid    <= nxt.uid;
                req_ch.proposal_id <= nxt.pid;
                req_ch.accepted_in <= nxt.acc;
                req_ch.value       <= nxt.val;
                req_ch.valid       <= 1'b1;
                send_gap = send_jitter ? $urandom_range(0, 3) : 0;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Stall the result side at random after each transaction, when receive jitter is on
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_fire)
                recv_stall = recv_jitter ? $urandom_range(0, 3) : 0;
            if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic add_item(input logic [2:0] f, input logic [UID_W-1:0] u,
                            input logic [ID_W-1:0] pid, input logic [ID_W-1:0] acc,
                            input logic [VAL_W-1:0] v);
        request_queue.push_back('{func: f, uid: u, pid: pid, acc: acc, val: v});
        queued_total++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ACTIVE)
            cfg_active = data[0];
        else
            cfg_window = data;
    endtask

    // Hold until every request is taken and every expected result has come
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || taken_total != queued_total ||
               pending_replies.size() != 0);
    endtask

    // Mostly IDs near a slowly rising base, so equal/higher/lower all occur
    function automatic logic [ID_W-1:0] pick_id();
        int          sel;
        logic [63:0] wide;
        sel  = $urandom_range(0, 19);
        wide = {$urandom, $urandom};
        if (sel < 12)
            return id_base + $urandom_range(0, 2);
        else if (sel < 15)
            return id_base - $urandom_range(1, 4);
        else if (sel < 17)
            return last_pid;
        else if (sel == 17)
            return '0;
        else if (sel == 18)
            return '1;
        return wide[ID_W-1:0];
    endfunction

    task automatic add_random_item();
        int               sel;
        logic [63:0]      w1;
        logic [63:0]      w2;
        logic [31:0]      r32;
        logic [2:0]       f;
        logic [UID_W-1:0] u;
        logic [ID_W-1:0]  pid;
        logic [ID_W-1:0]  acc;
        logic [VAL_W-1:0] v;
        sel = $urandom_range(0, 99);
        w1  = {$urandom, $urandom};
        w2  = {$urandom, $urandom};
        r32 = $urandom;
        u   = r32[UID_W-1:0];
        pid = pick_id();
        acc = $urandom_range(0, 1) ? w1[ID_W-1:0] : pick_id();
        v   = w2[VAL_W-1:0];
        if (sel < 28)
            f = FUNC_PREPARE;
        else if (sel < 56)
        begin
            f = FUNC_ACCEPT;
            // repeat an earlier accept often enough to hit the re-send path
            if ($urandom_range(0, 9) < 4)
            begin
                pid = last_pid;
                v   = last_val;
            end
            last_pid = pid;
            last_val = v;
        end
        else if (sel < 74)
            f = FUNC_PERSISTED;
        else if (sel < 88)
            f = FUNC_TICK;
        else if (sel < 96)
        begin
            f   = FUNC_RECOVER;
            pid = id_base + $urandom_range(0, 2);
            acc = ($urandom_range(0, 3) == 0) ? '0 : pid - $urandom_range(0, 1);
        end
        else
            f = 3'(FUNC_FIRST_UNUSED + $urandom_range(0, 2));
        if ($urandom_range(0, 5) == 0)
            id_base = id_base + $urandom_range(1, 2);
        add_item(f, u, pid, acc, v);
    endtask

    // Watchdog
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int          p;
        logic [31:0] window;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_ACTIVE;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_TICK;
        req_ch.from_uid    = '0;
        req_ch.proposal_id = '0;
        req_ch.accepted_in = '0;
        req_ch.value       = '0;
        rsp_ch.ready       = 1'b0;

        cfg_active    = 1'b1;
        cfg_window    = LIVENESS_RESET;
        promised      = '0;
        acc_id        = '0;
        acc_val       = '0;
        promise_armed = 1'b0;
        promise_dest  = '0;
        permit_armed  = 1'b0;
        permit_dest   = '0;
        idle_ticks    = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero ID while nothing promised, then the promise is released
        add_item(FUNC_PREPARE,   16'h0000, 48'd0, '0, '0);
        add_item(FUNC_PERSISTED, 16'h1234, '1, '1, '1);
        // arm a promise, busy slot, re-send, nack with zero and lower ID
        add_item(FUNC_PREPARE,   16'hFFFF, 48'd5, '0, '0);
        add_item(FUNC_PREPARE,   16'h0001, 48'd9, '0, '0);
        add_item(FUNC_PREPARE,   16'h0002, 48'd5, '0, '0);
        add_item(FUNC_PREPARE,   16'h0003, 48'd0, '0, '0);
        add_item(FUNC_PREPARE,   16'h0004, 48'd3, '0, '0);
        // arm a permit, busy slot, nack, then release both slots at once
        add_item(FUNC_ACCEPT,    16'h0005, 48'd5, '0, '1);
        add_item(FUNC_ACCEPT,    16'h0006, 48'd6, '0, 64'h1);
        add_item(FUNC_ACCEPT,    16'h0007, 48'd4, '0, 64'h2);
        add_item(FUNC_PERSISTED, 16'h0000, '0, '0, '0);
        // permit re-send, largest ID, promise re-send, permit only, nothing pending
        add_item(FUNC_ACCEPT,    16'h0008, 48'd5, '0, '1);
        add_item(FUNC_ACCEPT,    16'hFFFF, '1, '0, '0);
        add_item(FUNC_PREPARE,   16'h0009, '1, '0, '0);
        add_item(FUNC_PERSISTED, 16'h0000, '0, '0, '0);
        add_item(FUNC_PERSISTED, 16'h0000, '0, '0, '0);
        // recover, unused codes, then arm both slots
        add_item(FUNC_RECOVER,   16'hFFFF, 48'd7, '1, 64'hAAAA_AAAA_AAAA_AAAA);
        add_item(FUNC_FIRST_UNUSED, 16'hFFFF, '1, '1, '1);
        add_item(FUNC_LAST_UNUSED,  16'h5555, 48'h5555_5555_5555, '0, '1);
        add_item(FUNC_ACCEPT,    16'h000A, 48'd8, '0, 64'h5555_5555_5555_5555);
        add_item(FUNC_PREPARE,   16'h000B, 48'd10, '0, '0);
        wait_drained();

        // inactive: persisted clears both slots silently, no message for anything
        write_reg(CFG_ACTIVE, 32'd0);
        add_item(FUNC_PERSISTED, 16'h0000, '0, '0, '0);
        add_item(FUNC_PREPARE,   16'h000C, 48'd20, '0, '0);
        add_item(FUNC_PREPARE,   16'h000D, 48'd3, '0, '0);
        add_item(FUNC_ACCEPT,    16'h000E, 48'd20, '0, 64'h77);
        add_item(FUNC_ACCEPT,    16'h000F, 48'd20, '0, 64'h77);
        add_item(FUNC_RECOVER,   16'h0000, '0, '0, '0);
        wait_drained();

        // zero window: a single tick already expires the prepare
        write_reg(CFG_ACTIVE, 32'd1);
        write_reg(CFG_LIVENESS, 32'd0);
        add_item(FUNC_TICK,      16'h0000, '0, '0, '0);
        add_item(FUNC_PREPARE,   16'h0010, 48'd4, '0, '0);
        add_item(FUNC_PERSISTED, 16'h0000, '0, '0, '0);
        wait_drained();

        // random phases, each under its own setting, drained before reconfiguring
        for (p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: window = LIVENESS_RESET;
                1: window = 32'd0;
                2: window = $urandom_range(1, 8);
                3: window = '1;
                4: window = 32'd3;
                default: window = $urandom;
            endcase
            write_reg(CFG_ACTIVE, (p == 2) ? 32'd0 : 32'd1);
            write_reg(CFG_LIVENESS, window);
            send_jitter = (p != 1 && p != 4);
            recv_jitter = (p != 1 && p != 3);
            repeat (RAND_ITEMS_PER_PHASE) add_random_item();
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
